[rtl/core/tkd_pkg.sv]
// ---------------------------------------------------------------------------
// tkd_pkg
// Shared types and constants of the touch key detector with debounce.
// ---------------------------------------------------------------------------
package tkd_pkg;

   localparam int MAX_KEYS     = 8;
   localparam int COUNT_W      = 12;
   localparam int SUM_W        = 15;
   localparam int TH_W         = SUM_W + 2;
   localparam int PASS_W       = 3;
   localparam int KEY_W        = 4;
   localparam int CNT_W        = 4;
   localparam int ADDR_W       = 5;
   localparam int DATA_W       = 32;

   localparam int DEF_NUM_KEYS = 8;
   localparam int DEF_SAMPLES  = 5;

   localparam logic [CNT_W-1:0]   PRESS_COUNT   = 4'd10;
   localparam logic [CNT_W-1:0]   REARM_COUNT   = 4'd10;
   localparam logic [CNT_W-1:0]   PRESS_PARK    = 4'd15;
   localparam logic [COUNT_W-1:0] REF_RESET     = 12'hFFF;

   localparam logic CMD_PASS      = 1'b0;
   localparam logic CMD_READ      = 1'b1;
   localparam logic KIND_DECISION = 1'b0;
   localparam logic KIND_READ     = 1'b1;

   typedef struct packed {
      logic               cmd;
      logic [COUNT_W-1:0] charge_count_0;
      logic [COUNT_W-1:0] charge_count_1;
      logic [COUNT_W-1:0] charge_count_2;
      logic [COUNT_W-1:0] charge_count_3;
      logic [COUNT_W-1:0] charge_count_4;
      logic [COUNT_W-1:0] charge_count_5;
      logic [COUNT_W-1:0] charge_count_6;
      logic [COUNT_W-1:0] charge_count_7;
   } tkd_req_type;

   typedef struct packed {
      logic             result_kind;
      logic             press_event;
      logic [KEY_W-1:0] key_code;
   } tkd_rsp_type;

   // what the lanes hand to the merge stage for one result-producing request
   typedef struct packed {
      logic                cmd;
      logic [MAX_KEYS-1:0] hits;
   } tkd_grp_type;

endpackage

[rtl/core/tkd_lane.sv]
// ---------------------------------------------------------------------------
// tkd_lane
// One channel: accumulates charge counts over a group and flags a touch.
// ---------------------------------------------------------------------------
module tkd_lane
   import tkd_pkg::*;
#(
   parameter int SAMPLES = DEF_SAMPLES
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               acc_en,
   input  logic               last,
   input  logic [COUNT_W-1:0] count,
   input  logic [COUNT_W-1:0] ref_level,
   output logic               hit
);

   localparam logic [TH_W-1:0] SAMPLES_W = TH_W'(SAMPLES);

   logic [SUM_W-1:0] sum_ff, sum_in, new_sum;
   logic [TH_W-1:0]  thr_base, thr;

   // floor(sum / S) > ref + 1  <=>  sum >= S * (ref + 2)
   always_comb begin
      new_sum  = sum_ff + SUM_W'(count);
      thr_base = TH_W'(ref_level) + TH_W'(2);
      thr      = TH_W'(thr_base * SAMPLES_W);
      hit      = (TH_W'(new_sum) >= thr);
      sum_in   = sum_ff;
      if (acc_en) begin
         sum_in = last ? '0 : new_sum;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff <= '0;
      end else begin
         sum_ff <= sum_in;
      end
   end

endmodule

[rtl/core/tkd_merge.sv]
// ---------------------------------------------------------------------------
// tkd_merge
// Combines lane hits into a key, runs the debounce filter, holds the result.
// ---------------------------------------------------------------------------
module tkd_merge
   import tkd_pkg::*;
#(
   parameter int NUM_KEYS = DEF_NUM_KEYS
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        in_valid,
   input  tkd_grp_type in_grp,
   output logic        in_stall,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output tkd_rsp_type rsp_payload
);

   logic             s1_valid_ff, s1_valid_in;
   tkd_grp_type      s1_ff;
   logic             out_valid_ff, out_valid_in;
   tkd_rsp_type      rsp_ff, rsp_in;
   logic [CNT_W-1:0] press_ff, press_in, release_ff, release_in;
   logic [KEY_W-1:0] latch_ff, latch_in;
   logic [KEY_W-1:0] key;
   logic [CNT_W-1:0] press_tmp, release_tmp;
   logic             out_load, s1_move, ev;

   always_comb begin
      out_load = !out_valid_ff || !rsp_stall;
      s1_move  = s1_valid_ff && out_load;
      in_stall = s1_valid_ff && !out_load;

      s1_valid_in = s1_valid_ff;
      if (in_valid && !in_stall) begin
         s1_valid_in = 1'b1;
      end else if (s1_move) begin
         s1_valid_in = 1'b0;
      end

      out_valid_in = out_valid_ff;
      if (s1_move) begin
         out_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         out_valid_in = 1'b0;
      end

      // highest touched channel wins
      key = '0;
      for (int i = 0; i < MAX_KEYS; i++) begin
         if (i < NUM_KEYS && s1_ff.hits[i]) begin
            key = KEY_W'(i + 1);
         end
      end

      press_in    = press_ff;
      release_in  = release_ff;
      latch_in    = latch_ff;
      press_tmp   = press_ff;
      release_tmp = release_ff;
      ev          = 1'b0;
      rsp_in      = rsp_ff;

      if (s1_move) begin
         if (s1_ff.cmd == CMD_READ) begin
            rsp_in.result_kind = KIND_READ;
            rsp_in.press_event = 1'b0;
            rsp_in.key_code    = latch_ff;
            latch_in           = '0;
         end else begin
            if (key != '0) begin
               release_in = '0;
               if (press_ff < PRESS_COUNT) begin
                  press_tmp = press_ff + CNT_W'(1);
               end
               press_in = press_tmp;
               if (press_tmp == PRESS_COUNT) begin
                  press_in = PRESS_PARK;
                  latch_in = key;
                  ev       = 1'b1;
               end
            end else begin
               if (release_ff < REARM_COUNT) begin
                  release_tmp = release_ff + CNT_W'(1);
               end
               release_in = release_tmp;
               if (release_tmp == REARM_COUNT) begin
                  press_in = '0;
               end
            end
            rsp_in.result_kind = KIND_DECISION;
            rsp_in.press_event = ev;
            rsp_in.key_code    = key;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         press_ff     <= '0;
         release_ff   <= '0;
         latch_ff     <= '0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
         press_ff     <= press_in;
         release_ff   <= release_in;
         latch_ff     <= latch_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && !in_stall) begin
         s1_ff <= in_grp;
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_valid   = out_valid_ff;
   assign rsp_payload = rsp_ff;

`ifndef ASSERT_OFF
   a_event_decision: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.press_event |->
         rsp_payload.result_kind == KIND_DECISION && rsp_payload.key_code != '0)
      else $error("press event without a key");

   a_key_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_payload.key_code <= KEY_W'(NUM_KEYS))
      else $error("key code beyond channel count");

   a_press_cnt: assert property (@(posedge clock) disable iff (reset)
      press_ff <= PRESS_COUNT || press_ff == PRESS_PARK)
      else $error("press counter out of range");

   a_release_cnt: assert property (@(posedge clock) disable iff (reset)
      release_ff <= REARM_COUNT)
      else $error("release counter out of range");

   a_s1_hold: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !s1_move |=> s1_valid_ff && $stable(s1_ff))
      else $error("held request lost in merge stage");
`endif

endmodule

[rtl/core/touch_key_detect_debounce.sv]
// ---------------------------------------------------------------------------
// touch_key_detect_debounce
// Touch key detector: per-channel accumulation lanes, key merge, debounce.
//
//   channel | ports                     | moves
//   --------+---------------------------+-------------------------------------
//   request | req_valid/stall/payload   | measurement pass or read command
//   result  | rsp_valid/stall/payload   | group decision or read answer
//   config  | psel..pready (APB)        | ref_level_0..7 at byte 4*i
//
// One request per cycle while req_stall is low. A result leaves through the
// merge register, then the output register, after the request that causes it;
// mid-group passes give none. Up to two results are held against rsp_stall;
// req_stall rises only when both are full and the output is stalled.
// Reset is synchronous; references come up at 4095, no sweep.
// ---------------------------------------------------------------------------
module touch_key_detect_debounce
   import tkd_pkg::*;
#(
   parameter int NUM_KEYS = DEF_NUM_KEYS,
   parameter int SAMPLES  = DEF_SAMPLES
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  tkd_req_type       req_payload,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output tkd_rsp_type       rsp_payload,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [ADDR_W-1:0] paddr,
   input  logic [DATA_W-1:0] pwdata,
   output logic [DATA_W-1:0] prdata,
   output logic              pready
);

   logic [COUNT_W-1:0] ref_ff [MAX_KEYS];
   logic [COUNT_W-1:0] counts [MAX_KEYS];
   logic [MAX_KEYS-1:0] hits;
   logic [PASS_W-1:0]  pass_ff, pass_in;
   logic               accept, acc_en, last, grp_valid;
   logic [2:0]         reg_idx;
   tkd_grp_type        grp;

   // configuration registers
   assign pready  = 1'b1;
   assign reg_idx = paddr[4:2];
   assign prdata  = DATA_W'(ref_ff[reg_idx]);

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < MAX_KEYS; i++) begin
            ref_ff[i] <= REF_RESET;
         end
      end else if (psel && penable && pwrite && pready) begin
         ref_ff[reg_idx] <= pwdata[COUNT_W-1:0];
      end
   end

   always_comb begin
      counts[0] = req_payload.charge_count_0;
      counts[1] = req_payload.charge_count_1;
      counts[2] = req_payload.charge_count_2;
      counts[3] = req_payload.charge_count_3;
      counts[4] = req_payload.charge_count_4;
      counts[5] = req_payload.charge_count_5;
      counts[6] = req_payload.charge_count_6;
      counts[7] = req_payload.charge_count_7;
   end

   assign accept    = req_valid && !req_stall;
   assign acc_en    = accept && (req_payload.cmd == CMD_PASS);
   assign last      = (pass_ff == PASS_W'(SAMPLES - 1));
   assign grp_valid = req_valid && ((req_payload.cmd == CMD_READ) || last);

   always_comb begin
      pass_in = pass_ff;
      if (acc_en) begin
         pass_in = last ? '0 : pass_ff + PASS_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pass_ff <= '0;
      end else begin
         pass_ff <= pass_in;
      end
   end

   for (genvar g = 0; g < MAX_KEYS; g++) begin : g_lane
      if (g < NUM_KEYS) begin : g_on
         tkd_lane #(
            .SAMPLES (SAMPLES)
         ) u_lane (
            .clock     (clock),
            .reset     (reset),
            .acc_en    (acc_en),
            .last      (last),
            .count     (counts[g]),
            .ref_level (ref_ff[g]),
            .hit       (hits[g])
         );
      end else begin : g_off
         assign hits[g] = 1'b0;
      end
   end

   assign grp.cmd  = req_payload.cmd;
   assign grp.hits = hits;

   tkd_merge #(
      .NUM_KEYS (NUM_KEYS)
   ) u_merge (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (grp_valid),
      .in_grp      (grp),
      .in_stall    (req_stall),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

endmodule

[tb/sv/tb_touch_key_detect_debounce.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_touch_key_detect_debounce
// Self-checking bench for the touch key detector. A short table of scan
// passes and reads comes first, then random touch episodes of pressed and
// released groups under five reference settings and several idling patterns,
// one of which holds the result side off long enough to back up the request
// side. Every result is compared with the bench model or with a table answer.
// ---------------------------------------------------------------------------
module tb_touch_key_detect_debounce;
   import tkd_pkg::*;

   localparam int CYCLE_LIMIT = 200000;
   localparam int LONG_HOLD   = 400;
   localparam int SETTLE_WAIT = 6;

   typedef enum int {REFS_MID, REFS_ZERO, REFS_FULL, REFS_ANY} ref_style_type;

   typedef struct packed {
      logic        new_refs;
      tkd_req_type req;
      logic        fixed;
      logic        has;
      tkd_rsp_type want;
   } dir_row_type;

   localparam tkd_req_type READ_REQ = '{cmd: CMD_READ, default: '0};
   localparam tkd_req_type ALL_MAX  = '{cmd: CMD_PASS, default: 12'hFFF};
   localparam tkd_req_type ALL_ZERO = '{cmd: CMD_PASS, default: '0};
   localparam tkd_req_type CH0_MAX  = '{cmd: CMD_PASS, charge_count_0: 12'hFFF, default: '0};
   localparam tkd_req_type CH5_MAX  = '{cmd: CMD_PASS, charge_count_5: 12'hFFF, default: '0};
   localparam tkd_req_type CH37_MAX = '{cmd: CMD_PASS, charge_count_3: 12'hFFF,
                                        charge_count_7: 12'hFFF, default: '0};

   localparam tkd_rsp_type NO_ANSWER  = '0;
   localparam tkd_rsp_type READ_EMPTY = '{KIND_READ, 1'b0, 4'd0};
   localparam tkd_rsp_type GROUP_NONE = '{KIND_DECISION, 1'b0, 4'd0};
   localparam tkd_rsp_type GROUP_KEY1 = '{KIND_DECISION, 1'b0, 4'd1};
   localparam tkd_rsp_type GROUP_KEY8 = '{KIND_DECISION, 1'b0, 4'd8};

   // directed run: untouched refs first, then ch0 at 0, ch1..6 at 2000, ch7 at 4093
   dir_row_type plan [0:22] = '{
      '{1'b0, READ_REQ, 1'b1, 1'b1, READ_EMPTY},
      '{1'b0, ALL_MAX,  1'b1, 1'b0, NO_ANSWER},
      '{1'b0, ALL_MAX,  1'b1, 1'b0, NO_ANSWER},
      '{1'b0, ALL_MAX,  1'b1, 1'b0, NO_ANSWER},
      '{1'b0, ALL_MAX,  1'b1, 1'b0, NO_ANSWER},
      '{1'b0, ALL_MAX,  1'b1, 1'b1, GROUP_NONE},
      '{1'b1, CH0_MAX,  1'b1, 1'b0, NO_ANSWER},
      '{1'b0, CH0_MAX,  1'b1, 1'b0, NO_ANSWER},
      '{1'b0, READ_REQ, 1'b1, 1'b1, READ_EMPTY},
      '{1'b0, CH0_MAX,  1'b1, 1'b0, NO_ANSWER},
      '{1'b0, CH0_MAX,  1'b1, 1'b0, NO_ANSWER},
      '{1'b0, CH0_MAX,  1'b1, 1'b1, GROUP_KEY1},
      '{1'b0, CH37_MAX, 1'b1, 1'b0, NO_ANSWER},
      '{1'b0, CH37_MAX, 1'b1, 1'b0, NO_ANSWER},
      '{1'b0, CH37_MAX, 1'b1, 1'b0, NO_ANSWER},
      '{1'b0, CH37_MAX, 1'b1, 1'b0, NO_ANSWER},
      '{1'b0, CH37_MAX, 1'b1, 1'b1, GROUP_KEY8},
      '{1'b0, CH5_MAX,  1'b0, 1'b0, NO_ANSWER},
      '{1'b0, ALL_ZERO, 1'b0, 1'b0, NO_ANSWER},
      '{1'b0, CH5_MAX,  1'b0, 1'b0, NO_ANSWER},
      '{1'b0, ALL_ZERO, 1'b0, 1'b0, NO_ANSWER},
      '{1'b0, CH5_MAX,  1'b0, 1'b0, NO_ANSWER},
      '{1'b0, READ_REQ, 1'b1, 1'b1, READ_EMPTY}
   };

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_stall;
   tkd_req_type       req_payload = '0;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   tkd_rsp_type       rsp_payload;
   logic              psel = 1'b0;
   logic              penable = 1'b0;
   logic              pwrite = 1'b0;
   logic [ADDR_W-1:0] paddr = '0;
   logic [DATA_W-1:0] pwdata = '0;
   logic [DATA_W-1:0] prdata;
   logic              pready;

   // model state of the detector
   logic [COUNT_W-1:0] exp_ref [MAX_KEYS] = '{default: REF_RESET};
   logic [SUM_W-1:0]   exp_sum [MAX_KEYS] = '{default: '0};
   logic [PASS_W-1:0]  exp_pass = '0;
   logic [CNT_W-1:0]   exp_press = '0;
   logic [CNT_W-1:0]   exp_release = '0;
   logic [KEY_W-1:0]   exp_latched = '0;

   tkd_rsp_type due_answers [$];

   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   int hold_asked = 0;
   int hold_given = 0;
   int hold_left = 0;
   int faults = 0;
   int sent = 0;
   int reads_sent = 0;
   int checked = 0;
   int press_events = 0;
   int cycle_count = 0;

   touch_key_detect_debounce u_top (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .psel        (psel),
      .penable     (penable),
      .pwrite      (pwrite),
      .paddr       (paddr),
      .pwdata      (pwdata),
      .prdata      (prdata),
      .pready      (pready)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("[touch_key_detect_debounce] ERROR");
         $finish;
      end
   end

   task automatic log_fault(input string what);
      faults++;
      if (faults <= 10)
         $display("mismatch at %0t: %s", $realtime, what);
   endtask

   // one request through the model; returns 1 when it yields an answer
   function automatic bit key_answer(input tkd_req_type r, output tkd_rsp_type a);
      logic [MAX_KEYS*COUNT_W-1:0] lanes;
      logic [KEY_W-1:0]            key;
      int unsigned                 avg;
      logic                        ev;
      lanes = r[MAX_KEYS*COUNT_W-1:0];
      a = '0;
      if (r.cmd == CMD_READ) begin
         a.result_kind = KIND_READ;
         a.key_code = exp_latched;
         exp_latched = '0;
         return 1'b1;
      end
      for (int ch = 0; ch < DEF_NUM_KEYS; ch++)
         exp_sum[ch] = exp_sum[ch] +
                       SUM_W'(lanes[(MAX_KEYS-ch)*COUNT_W-1 -: COUNT_W]);
      if (int'(exp_pass) + 1 < DEF_SAMPLES) begin
         exp_pass++;
         return 1'b0;
      end
      key = '0;
      for (int ch = 0; ch < DEF_NUM_KEYS; ch++) begin
         avg = exp_sum[ch] / DEF_SAMPLES;
         if (avg > exp_ref[ch] + 1)
            key = KEY_W'(ch + 1);
      end
      ev = 1'b0;
      if (key != '0) begin
         exp_release = '0;
         if (exp_press < PRESS_COUNT)
            exp_press++;
         if (exp_press == PRESS_COUNT) begin
            // parked so a held key gives no second event
            exp_press = PRESS_PARK;
            exp_latched = key;
            ev = 1'b1;
         end
      end else begin
         if (exp_release < REARM_COUNT)
            exp_release++;
         if (exp_release == REARM_COUNT)
            exp_press = '0;
      end
      exp_pass = '0;
      exp_sum = '{default: '0};
      a.result_kind = KIND_DECISION;
      a.press_event = ev;
      a.key_code = key;
      return 1'b1;
   endfunction

   // touched channels sit above their reference (capped at 4095), the rest at or below it; noisy ones are random
   function automatic tkd_req_type make_pass(input logic [MAX_KEYS-1:0] touched,
                                             input bit noisy);
      logic [MAX_KEYS*COUNT_W-1:0] lanes;
      int lo;
      for (int ch = 0; ch < MAX_KEYS; ch++) begin
         lo = exp_ref[ch] + 2;
         if (lo > 4095)
            lo = 4095;
         if (noisy)
            lanes[(MAX_KEYS-ch)*COUNT_W-1 -: COUNT_W] = COUNT_W'($urandom_range(4095, 0));
         else if (touched[ch])
            lanes[(MAX_KEYS-ch)*COUNT_W-1 -: COUNT_W] = COUNT_W'($urandom_range(4095, lo));
         else
            lanes[(MAX_KEYS-ch)*COUNT_W-1 -: COUNT_W] =
               COUNT_W'($urandom_range(exp_ref[ch], 0));
      end
      return tkd_req_type'({CMD_PASS, lanes});
   endfunction

   task automatic offer(input tkd_req_type r, input bit fixed = 1'b0,
                        input bit has = 1'b0, input tkd_rsp_type want = '0);
      tkd_rsp_type a;
      bit got;
      if (send_idle_pct > 0 && $urandom_range(99, 0) < send_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99, 0) < send_idle_pct);
      end
      req_valid <= 1'b1;
      req_payload <= r;
      do @(posedge clock); while (req_stall);
      got = key_answer(r, a);
      if (fixed) begin
         got = has;
         a = want;
      end
      if (got) begin
         due_answers.push_back(a);
         if (a.press_event)
            press_events++;
      end
      sent++;
      if (r.cmd == CMD_READ)
         reads_sent++;
   endtask

   // sender goes quiet until every answer is in and the pipe is empty
   task automatic settle();
      req_valid <= 1'b0;
      while (due_answers.size() != 0)
         @(posedge clock);
      repeat (SETTLE_WAIT) @(posedge clock);
   endtask

   task automatic set_ref(input int idx, input logic [DATA_W-1:0] word);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= ADDR_W'(4 * idx);
      pwdata <= word;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      exp_ref[idx] = word[COUNT_W-1:0];
      @(posedge clock);
   endtask

   task automatic apply_refs(input ref_style_type style);
      logic [COUNT_W-1:0] v;
      for (int i = 0; i < MAX_KEYS; i++) begin
         case (style)
            REFS_ZERO: v = '0;
            REFS_FULL: v = '1;
            REFS_MID:  v = COUNT_W'($urandom_range(3000, 1000));
            default:   v = COUNT_W'($urandom_range(4095, 0));
         endcase
         // junk in the upper bits must be dropped
         set_ref(i, {20'($urandom), v});
      end
   endtask

   // touch episodes: some pressed groups, then some released ones, with reads mixed in
   task automatic run_touches(input int quota);
      tkd_req_type r;
      logic [MAX_KEYS-1:0] mask;
      int goal;
      int pressed;
      int released;
      goal = sent + quota;
      while (sent < goal) begin
         if ($urandom_range(99, 0) < 70)
            mask = MAX_KEYS'(1) << $urandom_range(MAX_KEYS-1, 0);
         else
            mask = MAX_KEYS'($urandom);
         pressed = $urandom_range(14, 0);
         released = $urandom_range(14, 0);
         for (int g = 0; g < pressed + released; g++) begin
            for (int p = 0; p < DEF_SAMPLES; p++) begin
               if ($urandom_range(99, 0) < 8) begin
                  r = make_pass('0, 1'b1);
                  r.cmd = CMD_READ;
                  offer(r);
               end
               offer(make_pass((g < pressed) ? mask : '0, $urandom_range(99, 0) < 10));
            end
         end
      end
   endtask

   always @(posedge clock) begin : answer_check
      tkd_rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (due_answers.size() == 0) begin
            log_fault($sformatf("result with none expected: %p", rsp_payload));
         end else begin
            want = due_answers.pop_front();
            checked++;
            if (rsp_payload.result_kind !== want.result_kind ||
                rsp_payload.press_event !== want.press_event ||
                rsp_payload.key_code !== want.key_code)
               log_fault($sformatf("expected kind %0d event %0d key %0d, got %0d %0d %0d",
                                   want.result_kind, want.press_event, want.key_code,
                                   rsp_payload.result_kind, rsp_payload.press_event,
                                   rsp_payload.key_code));
         end
      end
      if (hold_left == 0 && hold_asked != hold_given) begin
         hold_given++;
         hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= recv_stall_pct > 0 && $urandom_range(99, 0) < recv_stall_pct;
      end
   end

   initial begin
      tkd_req_type r;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      foreach (plan[i]) begin
         if (plan[i].new_refs) begin
            settle();
            for (int k = 0; k < MAX_KEYS; k++)
               set_ref(k, (k == 0) ? 0 : (k == MAX_KEYS-1) ? 4093 : 2000);
         end
         offer(plan[i].req, plan[i].fixed, plan[i].has, plan[i].want);
      end
      settle();

      for (int phase = 0; phase < 5; phase++) begin
         case (phase)
            0: begin
               send_idle_pct = 0;  recv_stall_pct = 0;  apply_refs(REFS_MID);
            end
            1: begin
               send_idle_pct = 67; recv_stall_pct = 0;  apply_refs(REFS_ZERO);
            end
            2: begin
               send_idle_pct = 0;  recv_stall_pct = 67; apply_refs(REFS_FULL);
            end
            3: begin
               send_idle_pct = 10; recv_stall_pct = 10; apply_refs(REFS_ANY);
            end
            default: begin
               send_idle_pct = 0;  recv_stall_pct = 0;  apply_refs(REFS_MID);
            end
         endcase
         run_touches(70);
         settle();
         if (phase == 4) begin
            // result side held off while requests keep coming, so the block backs up
            hold_asked++;
            for (int i = 0; i < 40; i++) begin
               r = make_pass(MAX_KEYS'($urandom), 1'b0);
               if (i % 2 == 0)
                  r.cmd = CMD_READ;
               offer(r);
            end
         end
         run_touches(70);
         settle();
      end

      $display("Sent %0d requests (%0d reads) under five reference settings and four idling",
               sent, reads_sent);
      $display("patterns; %0d results checked, %0d debounced presses seen.",
               checked, press_events);
      if (faults == 0 && due_answers.size() == 0) begin
         $display("[touch_key_detect_debounce] OK");
      end else begin
         $display("%0d faults", faults);
         $display("[touch_key_detect_debounce] ERROR");
      end
      $finish;
   end

endmodule
